[sv/hashed_token_scanner_macros.svh]
// Assertion macros used by the token scanner scan core.
`ifndef HASHED_TOKEN_SCANNER_MACROS_SVH
`define HASHED_TOKEN_SCANNER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define HTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/hts_pkg.sv]
// Package: types and constants of the hashed token scanner.
`default_nettype none
package hts_pkg;

  localparam int unsigned HTS_MAX_DEPTH_DEF = 15;

  localparam logic [7:0]  SEP_MAX     = 8'd32;
  localparam logic [7:0]  SEMI_BYTE   = 8'h3b;
  localparam logic [7:0]  NL_BYTE     = 8'd10;
  localparam logic [7:0]  ZERO_BYTE   = 8'h30;
  localparam logic [7:0]  NINE_BYTE   = 8'h39;
  localparam logic [15:0] LINE_MARK   = 16'h2f2f;
  localparam logic [15:0] OPEN_MARK   = 16'h2f2a;
  localparam logic [15:0] CALL_MARK   = 16'h2829;
  localparam logic [15:0] CLOSE_HASH  = 16'd65475;

  typedef struct packed {
    logic [15:0] token_value;
    logic        is_number;
    logic        is_call;
  } token_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] char_byte;
  } step_t;

  typedef struct packed {
    logic   valid;
    token_t tok;
  } result_t;

endpackage
`default_nettype wire

[sv/hts_ifs.sv]
// Interfaces: input byte channel and token result channel.
`default_nettype none
interface hts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface

interface hts_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] token_value;
  logic        is_number;
  logic        is_call;

  modport source (output valid, output token_value, output is_number, output is_call,
                  input ready);
  modport sink   (input valid, input token_value, input is_number, input is_call,
                  output ready);
endinterface
`default_nettype wire

[sv/hts_in_reg.sv]
// Input register: holds one accepted source byte for the scan step.
`default_nettype none
module hts_in_reg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  hts_in_if.sink           in_chan,
  input  wire logic        take,
  output hts_pkg::step_t   step
);
  import hts_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       load;

  assign in_chan.ready = !valid_r || take;
  assign load          = in_chan.valid && in_chan.ready;

  always_comb begin
    priority if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_chan.char_byte;
    end
  end

  assign step.valid     = valid_r;
  assign step.char_byte = byte_r;

endmodule
`default_nettype wire

[sv/hts_scan_core.sv]
// Scan core: token state, hash update and comment tracking per byte.
`default_nettype none
`include "hashed_token_scanner_macros.svh"
module hts_scan_core #(
  parameter int unsigned MAX_COMMENT_DEPTH = hts_pkg::HTS_MAX_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire hts_pkg::step_t step,
  input  wire logic        space,
  output logic             take,
  output hts_pkg::result_t res
);
  import hts_pkg::*;

  localparam int unsigned DEPTH_W = $clog2(MAX_COMMENT_DEPTH + 1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_COMMENT_DEPTH);

  typedef enum logic [1:0] {
    PH_SKIP  = 2'd0,
    PH_TOKEN = 2'd1,
    PH_LINE  = 2'd2
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [15:0]        hash_r, hash_nxt;
  logic [15:0]        last_r, last_nxt;
  logic               fdig_r, fdig_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic               emit;

  assign take = step.valid && space;

  always_comb begin
    logic [7:0] c;
    logic       semi;
    logic       sep;
    logic       start;
    logic [7:0] sc;
    c         = step.char_byte;
    semi      = (c == SEMI_BYTE);
    sep       = (c <= SEP_MAX) || semi;
    start     = 1'b0;
    sc        = c;
    phase_nxt = phase_r;
    hash_nxt  = hash_r;
    last_nxt  = last_r;
    fdig_nxt  = fdig_r;
    depth_nxt = depth_r;
    emit      = 1'b0;
    unique case (phase_r)
      PH_LINE: begin
        if (c == NL_BYTE) begin
          phase_nxt = PH_SKIP;
        end
      end
      PH_TOKEN: begin
        if (sep) begin
          phase_nxt = PH_SKIP;
          priority if (last_r == LINE_MARK) begin
            phase_nxt = PH_LINE;
          end else if (last_r == OPEN_MARK) begin
            if (depth_r < DEPTH_MAX) begin
              depth_nxt = depth_r + DEPTH_W'(1);
            end
          end else if (depth_r != '0) begin
            if (hash_r == CLOSE_HASH) begin
              depth_nxt = depth_r - DEPTH_W'(1);
            end
          end else begin
            emit = 1'b1;
          end
          start = semi && (last_r != LINE_MARK);
        end else begin
          last_nxt = {last_r[7:0], c};
          hash_nxt = (hash_r << 3) + (hash_r << 1) + {8'd0, c} - {8'd0, ZERO_BYTE};
        end
      end
      default: begin
        start = !(c <= SEP_MAX);
      end
    endcase
    if (start) begin
      phase_nxt = PH_TOKEN;
      last_nxt  = {8'd0, sc};
      hash_nxt  = {8'd0, sc} - {8'd0, ZERO_BYTE};
      fdig_nxt  = (sc >= ZERO_BYTE) && (sc <= NINE_BYTE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      hash_r  <= '0;
      last_r  <= '0;
      fdig_r  <= 1'b0;
      depth_r <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      hash_r  <= hash_nxt;
      last_r  <= last_nxt;
      fdig_r  <= fdig_nxt;
      depth_r <= depth_nxt;
    end
  end

  assign res.valid           = take && emit;
  assign res.tok.token_value = hash_r;
  assign res.tok.is_number   = fdig_r;
  assign res.tok.is_call     = (last_r == CALL_MARK);

  `HTS_ASSERT_NOW(a_depth_bound, 1'b1, depth_r <= DEPTH_MAX, "comment depth above maximum")
  `HTS_ASSERT_NOW(a_emit_outside, res.valid, depth_r == '0 && phase_r == PH_TOKEN, "comment emit")
  `HTS_ASSERT_NEXT(a_emit_phase, res.valid, phase_r != PH_LINE, "line comment after emit")

endmodule
`default_nettype wire

[sv/hts_out_reg.sv]
// Output register: holds one finished token until the receiver takes it.
`default_nettype none
module hts_out_reg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire hts_pkg::result_t res,
  output logic             space,
  hts_out_if.source        out_chan
);
  import hts_pkg::*;

  logic   valid_r;
  logic   valid_nxt;
  token_t tok_r;

  assign space = !valid_r || out_chan.ready;

  always_comb begin
    priority if (res.valid) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      tok_r <= res.tok;
    end
  end

  assign out_chan.valid       = valid_r;
  assign out_chan.token_value = tok_r.token_value;
  assign out_chan.is_number   = tok_r.is_number;
  assign out_chan.is_call     = tok_r.is_call;

endmodule
`default_nettype wire

[sv/hashed_token_scanner.sv]
// Top level: byte-serial token scanner with hashing and comment skipping.
// Usage:
//   in_chan takes one raw source byte per item (valid/ready). Bytes of 32
//   or less end a token; a semicolon ends one and starts a new ';' token.
//   out_chan gives one item per finished token outside comments: its hash,
//   whether it starts with a digit and whether it ends in "()".
//   Path: an accepted byte waits in the input register and is scanned from
//   there; a token it finishes is registered in the output register for out_chan.
//   Throughput: one byte per cycle unless the stall below holds, set by
//   the single scan step between the input register and the output register.
//   Stall: while a token waits on out_chan and ready is low, the scan step
//   holds; an empty input register still takes one byte, then in_chan.ready
//   stays low until the receiver takes the waiting token.
//   Reset (rst_n low, synchronous): both registers empty, scanner skipping
//   separators, comment depth zero. A token unfinished at end of stream
//   is never emitted.
`default_nettype none
module hashed_token_scanner #(
  parameter int unsigned MAX_COMMENT_DEPTH = hts_pkg::HTS_MAX_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  hts_in_if.sink    in_chan,
  hts_out_if.source out_chan
);
  import hts_pkg::*;

  step_t   step;
  result_t res;
  logic    take;
  logic    space;

  hts_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .take    (take),
    .step    (step)
  );

  hts_scan_core #(
    .MAX_COMMENT_DEPTH (MAX_COMMENT_DEPTH)
  ) u_scan_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .space (space),
    .take  (take),
    .res   (res)
  );

  hts_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .space    (space),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

[test/hashed_token_scanner_test.sv]
// Testbench: byte stream stimulus for the token scanner, checked against a scanning predictor.
`default_nettype none
module hashed_token_scanner_test;
  import hts_pkg::*;

  typedef enum logic [1:0] {
    SCAN_IDLE = 2'd0,
    SCAN_WORD = 2'd1,
    SCAN_LINE = 2'd2
  } scan_phase_e;

  typedef struct packed {
    logic [7:0] b;
    logic       pin;
    token_t     tok;
  } row_t;

  localparam token_t NO_TOK = '0;
  localparam int unsigned DEPTH_LIMIT = HTS_MAX_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 600;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 8;

  localparam row_t DIRECTED_ROWS [31] = '{
    '{8'hff, 1'b0, NO_TOK},
    '{8'h00, 1'b1, '{16'd207, 1'b0, 1'b0}},
    '{8'h21, 1'b0, NO_TOK},
    '{SEP_MAX, 1'b1, '{16'd65521, 1'b0, 1'b0}},
    '{NINE_BYTE, 1'b0, NO_TOK},
    '{NL_BYTE, 1'b1, '{16'd9, 1'b1, 1'b0}},
    '{8'h28, 1'b0, NO_TOK},
    '{8'h29, 1'b0, NO_TOK},
    '{8'h20, 1'b0, NO_TOK},
    '{8'h2a, 1'b0, NO_TOK},
    '{8'h2f, 1'b0, NO_TOK},
    '{8'h20, 1'b1, '{CLOSE_HASH, 1'b0, 1'b0}},
    '{8'h2f, 1'b0, NO_TOK},
    '{8'h2f, 1'b0, NO_TOK},
    '{8'h20, 1'b0, NO_TOK},
    '{SEMI_BYTE, 1'b0, NO_TOK},
    '{NL_BYTE, 1'b0, NO_TOK},
    '{8'h37, 1'b0, NO_TOK},
    '{SEMI_BYTE, 1'b1, '{16'd7, 1'b1, 1'b0}},
    '{8'h20, 1'b1, '{16'd11, 1'b0, 1'b0}},
    '{8'h2f, 1'b0, NO_TOK},
    '{8'h2a, 1'b0, NO_TOK},
    '{8'h20, 1'b0, NO_TOK},
    '{8'h78, 1'b0, NO_TOK},
    '{8'h20, 1'b0, NO_TOK},
    '{8'h2a, 1'b0, NO_TOK},
    '{8'h2f, 1'b0, NO_TOK},
    '{8'h20, 1'b0, NO_TOK},
    '{8'h34, 1'b0, NO_TOK},
    '{8'h32, 1'b0, NO_TOK},
    '{SEMI_BYTE, 1'b1, '{16'd42, 1'b1, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hts_in_if  in_bus ();
  hts_out_if out_bus ();

  hashed_token_scanner dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  scan_phase_e sc_phase = SCAN_IDLE;
  logic [15:0] sc_hash  = '0;
  logic [15:0] sc_tail  = '0;
  logic        sc_digit = 1'b0;
  int unsigned sc_depth = 0;

  token_t pending_tokens [$];
  int     mismatches = 0;
  int     bytes_sent = 0;
  bit     pin_now = 1'b0;
  token_t pin_tok = '0;
  bit     hold_req = 1'b0;
  bit     send_calm = 1'b0;
  bit     take_calm = 1'b0;

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  task feed_step(input logic [7:0] c, inout bit got, inout token_t tok);
    case (sc_phase)
      SCAN_LINE: begin
        if (c == NL_BYTE) sc_phase = SCAN_IDLE;
      end
      SCAN_WORD: begin
        if (c <= SEP_MAX) begin
          sc_phase = SCAN_IDLE;
          if (sc_tail == LINE_MARK) begin
            sc_phase = SCAN_LINE;
          end else if (sc_tail == OPEN_MARK) begin
            if (sc_depth < DEPTH_LIMIT) sc_depth++;
          end else if (sc_depth != 0) begin
            if (sc_hash == CLOSE_HASH) sc_depth--;
          end else begin
            got = 1'b1;
            tok = '{sc_hash, sc_digit, sc_tail == CALL_MARK};
          end
        end else begin
          sc_tail = {sc_tail[7:0], c};
          sc_hash = sc_hash * 16'd10 + {8'h00, c} - 16'd48;
        end
      end
      default: begin
        if (c > SEP_MAX) begin
          sc_phase = SCAN_WORD;
          sc_tail  = {8'h00, c};
          sc_hash  = {8'h00, c} - 16'd48;
          sc_digit = (c >= ZERO_BYTE) && (c <= NINE_BYTE);
        end
      end
    endcase
  endtask

  task scan_byte(input logic [7:0] c, output bit got, output token_t tok);
    got = 1'b0;
    tok = '0;
    if (c == SEMI_BYTE) begin
      feed_step(8'h00, got, tok);
      feed_step(c, got, tok);
    end else begin
      feed_step(c, got, tok);
    end
  endtask

  always @(posedge clk) begin : watch
    token_t want;
    token_t tok;
    bit     got;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending_tokens.size() == 0) begin
          flag_mismatch("unexpected token_value", int'(out_bus.token_value), -1);
        end else begin
          want = pending_tokens.pop_front();
          if (out_bus.token_value !== want.token_value)
            flag_mismatch("token_value", int'(out_bus.token_value),
                          int'(want.token_value));
          if (out_bus.is_number !== want.is_number)
            flag_mismatch("is_number", int'(out_bus.is_number), int'(want.is_number));
          if (out_bus.is_call !== want.is_call)
            flag_mismatch("is_call", int'(out_bus.is_call), int'(want.is_call));
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        scan_byte(in_bus.char_byte, got, tok);
        if (pin_now) begin
          got = 1'b1;
          tok = pin_tok;
        end
        if (got) pending_tokens.push_back(tok);
      end
    end
  end

  function automatic int pick_gap(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.char_byte <= b;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] word_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(127, 255));
    return 8'($urandom_range(33, 126));
  endfunction

  function automatic logic [7:0] sep_byte();
    if ($urandom_range(0, 9) == 0) return SEMI_BYTE;
    if ($urandom_range(0, 1) == 0) return 8'h20;
    return 8'($urandom_range(0, 32));
  endfunction

  task automatic emit_chunk();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      n = $urandom_range(1, 6);
      repeat (n) push_byte(word_byte());
      push_byte(sep_byte());
    end else if (kind < 45) begin
      n = $urandom_range(1, 5);
      repeat (n) push_byte(8'($urandom_range(ZERO_BYTE, NINE_BYTE)));
      push_byte(sep_byte());
    end else if (kind < 55) begin
      n = $urandom_range(0, 3);
      repeat (n) push_byte(word_byte());
      push_byte(8'h28);
      push_byte(8'h29);
      push_byte(sep_byte());
    end else if (kind < 65) begin
      n = $urandom_range(0, 2);
      repeat (n) push_byte(word_byte());
      push_byte(8'h2f);
      push_byte(8'h2f);
      push_byte(sep_byte());
      n = $urandom_range(0, 6);
      repeat (n) push_byte($urandom_range(0, 1) ? word_byte() : sep_byte());
      push_byte(NL_BYTE);
    end else if (kind < 75) begin
      n = $urandom_range(0, 2);
      repeat (n) push_byte(word_byte());
      push_byte(8'h2f);
      push_byte(8'h2a);
      push_byte(sep_byte());
    end else if (kind < 87) begin
      push_byte(8'h2a);
      push_byte(8'h2f);
      push_byte(sep_byte());
    end else if (kind < 90) begin
      n = $urandom_range(16, 18);
      repeat (n) begin
        push_byte(8'h2f);
        push_byte(8'h2a);
        push_byte(sep_byte());
      end
      n = $urandom_range(1, 15);
      repeat (n) begin
        push_byte(8'h2a);
        push_byte(8'h2f);
        push_byte(sep_byte());
      end
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : take
    int hold;
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        hold = pick_gap(take_calm);
      end
      if (hold > 0) begin
        out_bus.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && out_bus.ready));
      @(negedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("hashed_token_scanner_test failed");
    $finish;
  end

  initial begin : stimulus
    bit hold_done;
    hold_done = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.char_byte = 8'h00;
    out_bus.ready    = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (DIRECTED_ROWS[i]) begin
      pin_now = DIRECTED_ROWS[i].pin;
      pin_tok = DIRECTED_ROWS[i].tok;
      push_byte(DIRECTED_ROWS[i].b);
    end
    pin_now = 1'b0;
    while (bytes_sent < RANDOM_ITEMS + $size(DIRECTED_ROWS)) begin
      if (!hold_done && bytes_sent > 200) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      emit_chunk();
    end
    in_bus.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("hashed_token_scanner_test passed");
    end else begin
      $display("hashed_token_scanner_test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
